### src/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types, constants and blend arithmetic for the bilinear sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;

  localparam int CH_W     = 8;
  localparam int COORD_W  = 8;   // integer part of a coordinate, also texel_x/texel_y
  localparam int SAMPLE_W = 16;
  localparam int SIZE_W   = 9;

  // Texture store split into four banks by (row parity, column parity)
  localparam int NUM_BANKS  = 4;
  localparam int BANK_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / NUM_BANKS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  localparam int CMD_DEPTH = 4;
  localparam int CMD_AW    = $clog2(CMD_DEPTH);
  localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_WIDTH);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    CFG_TEXTURE_WIDTH  = 1'b0,
    CFG_TEXTURE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic                op;
    logic [COORD_W-1:0]  texel_x;
    logic [COORD_W-1:0]  texel_y;
    logic [CH_W-1:0]     in_red;
    logic [CH_W-1:0]     in_green;
    logic [CH_W-1:0]     in_blue;
    logic [SAMPLE_W-1:0] sample_x;
    logic [SAMPLE_W-1:0] sample_y;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
  } out_item_t;

  // Decoded transaction handed from front to back. For a write, x0/y0 hold
  // the texel position; for a sample, the four clamped neighbour coordinates.
  typedef struct packed {
    op_e                  op;
    logic [COORD_W-1:0]   x0;
    logic [COORD_W-1:0]   x1;
    logic [COORD_W-1:0]   y0;
    logic [COORD_W-1:0]   y1;
    logic [FRAC_BITS-1:0] tx;
    logic [FRAC_BITS-1:0] ty;
    rgb_t                 colour;
  } cmd_t;

  // a + floor(((b - a) * t + half) / 2^FRAC_BITS), ties round up
  function automatic logic [CH_W-1:0] lerp8(input logic [CH_W-1:0]      a,
                                            input logic [CH_W-1:0]      b,
                                            input logic [FRAC_BITS-1:0] t);
    logic signed [CH_W:0]                   diff;
    logic signed [CH_W+FRAC_BITS+1:0]       prod;
    logic signed [CH_W+1:0]                 step;
    logic        [CH_W+1:0]                 sum;
    diff = signed'({1'b0, b}) - signed'({1'b0, a});
    prod = diff * signed'({1'b0, t})
         + signed'((CH_W+FRAC_BITS+2)'(1) <<< (FRAC_BITS - 1));
    step = prod[CH_W+FRAC_BITS+1:FRAC_BITS];
    sum  = {2'b00, a} + unsigned'(step);
    return sum[CH_W-1:0];
  endfunction

  function automatic rgb_t lerp_rgb(input rgb_t c0, input rgb_t c1,
                                    input logic [FRAC_BITS-1:0] t);
    rgb_t r;
    r.red   = lerp8(c0.red,   c1.red,   t);
    r.green = lerp8(c0.green, c1.green, t);
    r.blue  = lerp8(c0.blue,  c1.blue,  t);
    return r;
  endfunction

endpackage

### src/bts_ram.sv
// ----------------------------------------------------------------------------
// bts_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bts_ram #(
  parameter  int Width = 24,
  parameter  int Depth = 16384,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/bts_front.sv
// ----------------------------------------------------------------------------
// bts_front
// Takes transactions, holds the size registers, clamps sample coordinates
// and queues decoded commands for the back end.
// ----------------------------------------------------------------------------
module bts_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  bts_pkg::in_item_t        in_item_i,
  output logic                     full_o,
  input  logic                     cfg_valid_i,
  input  bts_pkg::cfg_reg_e        cfg_index_i,
  input  logic [bts_pkg::SIZE_W-1:0] cfg_data_i,
  output logic                     cfg_ready_o,
  output logic                     cmd_valid_o,
  output bts_pkg::cmd_t            cmd_o,
  input  logic                     cmd_pop_i
);

  logic [bts_pkg::SIZE_W-1:0] width_q, width_d;
  logic [bts_pkg::SIZE_W-1:0] height_q, height_d;

  bts_pkg::cmd_t              cmd_mem_q [bts_pkg::CMD_DEPTH];
  logic [bts_pkg::CMD_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [bts_pkg::CMD_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [bts_pkg::CMD_CW-1:0] cnt_q, cnt_d;

  logic                        push_ok, pop_ok;
  logic [bts_pkg::COORD_W-1:0] w_last, h_last;
  logic [bts_pkg::COORD_W-1:0] sx_int, sy_int, x0, y0, x1, y1;
  bts_pkg::cmd_t               cmd_d;

  // last column/row in use; zero counts as one, oversize saturates
  function automatic logic [bts_pkg::COORD_W-1:0] last_index(
      input logic [bts_pkg::SIZE_W-1:0] size, input int unsigned max_size);
    logic [bts_pkg::SIZE_W-1:0] m1;
    m1 = size - bts_pkg::SIZE_W'(1);
    if (size == '0) begin
      return '0;
    end else if (size > bts_pkg::SIZE_W'(max_size)) begin
      return bts_pkg::COORD_W'(max_size - 1);
    end
    return m1[bts_pkg::COORD_W-1:0];
  endfunction

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bts_pkg::CFG_TEXTURE_WIDTH:  width_d  = cfg_data_i;
        bts_pkg::CFG_TEXTURE_HEIGHT: height_d = cfg_data_i;
      endcase
    end
  end

  // coordinate clamp
  always_comb begin
    w_last = last_index(width_q, bts_pkg::MAX_WIDTH);
    h_last = last_index(height_q, bts_pkg::MAX_HEIGHT);
    sx_int = in_item_i.sample_x[bts_pkg::SAMPLE_W-1:bts_pkg::FRAC_BITS];
    sy_int = in_item_i.sample_y[bts_pkg::SAMPLE_W-1:bts_pkg::FRAC_BITS];
    x0     = (sx_int > w_last) ? w_last : sx_int;
    y0     = (sy_int > h_last) ? h_last : sy_int;
    x1     = (x0 == w_last) ? x0 : x0 + bts_pkg::COORD_W'(1);
    y1     = (y0 == h_last) ? y0 : y0 + bts_pkg::COORD_W'(1);
  end

  always_comb begin
    cmd_d.op           = bts_pkg::op_e'(in_item_i.op);
    cmd_d.x1           = x1;
    cmd_d.y1           = y1;
    cmd_d.tx           = in_item_i.sample_x[bts_pkg::FRAC_BITS-1:0];
    cmd_d.ty           = in_item_i.sample_y[bts_pkg::FRAC_BITS-1:0];
    cmd_d.colour.red   = in_item_i.in_red;
    cmd_d.colour.green = in_item_i.in_green;
    cmd_d.colour.blue  = in_item_i.in_blue;
    if (in_item_i.op == bts_pkg::OP_SAMPLE) begin
      cmd_d.x0 = x0;
      cmd_d.y0 = y0;
    end else begin
      cmd_d.x0 = in_item_i.texel_x;
      cmd_d.y0 = in_item_i.texel_y;
    end
  end

  // command queue
  assign full_o      = (cnt_q == bts_pkg::CMD_CW'(bts_pkg::CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cmd_mem_q[rd_ptr_q];
  assign push_ok     = push_i && !full_o;
  assign pop_ok      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push_ok ? wr_ptr_q + bts_pkg::CMD_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop_ok ? rd_ptr_q + bts_pkg::CMD_AW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + bts_pkg::CMD_CW'(push_ok) - bts_pkg::CMD_CW'(pop_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bts_pkg::SIZE_RESET;
      height_q <= bts_pkg::SIZE_RESET;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      cmd_mem_q[wr_ptr_q] <= cmd_d;
    end
  end

endmodule

### src/bts_back.sv
// ----------------------------------------------------------------------------
// bts_back
// Banked texel store, two-stage bilinear blend and result queue.
// ----------------------------------------------------------------------------
module bts_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  bts_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output bts_pkg::out_item_t out_item_o
);

  logic issue, samp_issue, wr_issue, credit_ok, pop_ok;

  logic [bts_pkg::OUT_CW-1:0] credit_q, credit_d;

  bts_pkg::rgb_t bank_rd [bts_pkg::NUM_BANKS];

  // stage 1: banks read, neighbour selection info
  logic                         s1_valid_q;
  logic                         s1_x0p_q, s1_y0p_q, s1_xeq_q, s1_yeq_q;
  logic [bts_pkg::FRAC_BITS-1:0] s1_tx_q, s1_ty_q;

  // stage 2: horizontal blend done
  logic                          s2_valid_q;
  bts_pkg::rgb_t                 s2_top_q, s2_bot_q;
  logic [bts_pkg::FRAC_BITS-1:0] s2_ty_q;

  logic          xr, yb;
  bts_pkg::rgb_t tl, tr, bl, br, top_d, bot_d, res_d;

  // result queue
  bts_pkg::rgb_t              out_mem_q [bts_pkg::OUT_DEPTH];
  logic [bts_pkg::OUT_AW-1:0] out_wr_q, out_wr_d, out_rd_q, out_rd_d;
  logic [bts_pkg::OUT_CW-1:0] out_cnt_q, out_cnt_d;

  // credits bound samples in flight plus queued results to the queue depth
  assign credit_ok  = (credit_q < bts_pkg::OUT_CW'(bts_pkg::OUT_DEPTH));
  assign issue      = cmd_valid_i && (cmd_i.op == bts_pkg::OP_WRITE || credit_ok);
  assign samp_issue = issue && (cmd_i.op == bts_pkg::OP_SAMPLE);
  assign wr_issue   = issue && (cmd_i.op == bts_pkg::OP_WRITE);
  assign cmd_pop_o  = issue;

  for (genvar b = 0; b < bts_pkg::NUM_BANKS; b++) begin : g_bank
    localparam logic XP = 1'(b % 2);
    localparam logic YP = 1'(b / 2);
    logic [bts_pkg::COORD_W-1:0] col, row;
    logic [bts_pkg::BANK_AW-1:0] raddr, waddr;
    logic                        we;
    logic [$bits(bts_pkg::rgb_t)-1:0] rdata;

    assign col   = (cmd_i.x0[0] == XP) ? cmd_i.x0 : cmd_i.x1;
    assign row   = (cmd_i.y0[0] == YP) ? cmd_i.y0 : cmd_i.y1;
    assign raddr = {row[bts_pkg::COORD_W-1:1], col[bts_pkg::COORD_W-1:1]};
    assign waddr = {cmd_i.y0[bts_pkg::COORD_W-1:1], cmd_i.x0[bts_pkg::COORD_W-1:1]};
    assign we    = wr_issue && (cmd_i.x0[0] == XP) && (cmd_i.y0[0] == YP);

    bts_ram #(
      .Width ($bits(bts_pkg::rgb_t)),
      .Depth (bts_pkg::BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (cmd_i.colour),
      .re_i    (samp_issue),
      .raddr_i (raddr),
      .rdata_o (rdata)
    );

    assign bank_rd[b] = bts_pkg::rgb_t'(rdata);
  end

  // clamped neighbour shares the bank of the lower one
  always_comb begin
    xr    = s1_xeq_q ? s1_x0p_q : !s1_x0p_q;
    yb    = s1_yeq_q ? s1_y0p_q : !s1_y0p_q;
    tl    = bank_rd[{s1_y0p_q, s1_x0p_q}];
    tr    = bank_rd[{s1_y0p_q, xr}];
    bl    = bank_rd[{yb, s1_x0p_q}];
    br    = bank_rd[{yb, xr}];
    top_d = bts_pkg::lerp_rgb(tl, tr, s1_tx_q);
    bot_d = bts_pkg::lerp_rgb(bl, br, s1_tx_q);
    res_d = bts_pkg::lerp_rgb(s2_top_q, s2_bot_q, s2_ty_q);
  end

  assign empty_o = (out_cnt_q == '0);
  assign pop_ok  = pop_i && !empty_o;

  always_comb begin
    out_wr_d  = s2_valid_q ? out_wr_q + bts_pkg::OUT_AW'(1) : out_wr_q;
    out_rd_d  = pop_ok ? out_rd_q + bts_pkg::OUT_AW'(1) : out_rd_q;
    out_cnt_d = out_cnt_q + bts_pkg::OUT_CW'(s2_valid_q) - bts_pkg::OUT_CW'(pop_ok);
    credit_d  = credit_q + bts_pkg::OUT_CW'(samp_issue) - bts_pkg::OUT_CW'(pop_ok);
  end

  always_comb begin
    out_item_o.out_red   = out_mem_q[out_rd_q].red;
    out_item_o.out_green = out_mem_q[out_rd_q].green;
    out_item_o.out_blue  = out_mem_q[out_rd_q].blue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      credit_q   <= '0;
      out_wr_q   <= '0;
      out_rd_q   <= '0;
      out_cnt_q  <= '0;
    end else begin
      s1_valid_q <= samp_issue;
      s2_valid_q <= s1_valid_q;
      credit_q   <= credit_d;
      out_wr_q   <= out_wr_d;
      out_rd_q   <= out_rd_d;
      out_cnt_q  <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (samp_issue) begin
      s1_x0p_q <= cmd_i.x0[0];
      s1_y0p_q <= cmd_i.y0[0];
      s1_xeq_q <= (cmd_i.x1 == cmd_i.x0);
      s1_yeq_q <= (cmd_i.y1 == cmd_i.y0);
      s1_tx_q  <= cmd_i.tx;
      s1_ty_q  <= cmd_i.ty;
    end
    if (s1_valid_q) begin
      s2_top_q <= top_d;
      s2_bot_q <= bot_d;
      s2_ty_q  <= s1_ty_q;
    end
    if (s2_valid_q) begin
      out_mem_q[out_wr_q] <= res_d;
    end
  end

endmodule

### src/bilinear_texture_sampler.sv
// Throughput: one transaction per clock (write or sample), sustained while the result
//   queue is drained; the four texel reads of a sample come from four banks split by parity.
// Path: a sample accepted into the command queue passes the bank read register,
//   horizontal blend and vertical blend on its way to the result ports.
// Reset: asynchronous, active low; clears queues, pipeline valids and credits and
//   sets both size registers to 256. The texture store is not cleared.
// ----------------------------------------------------------------------------
// bilinear_texture_sampler
// Bilinear RGB texture sampler with clamp-to-edge addressing.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input transactions
  input  logic                       push_i,
  input  bts_pkg::in_item_t          in_item_i,
  output logic                       full_o,
  // results
  output logic                       empty_o,
  input  logic                       pop_i,
  output bts_pkg::out_item_t         out_item_o,
  // configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  bts_pkg::cfg_reg_e          cfg_index_i,
  input  logic [bts_pkg::SIZE_W-1:0] cfg_data_i
);

  // Decoded command between front and back. The front clamps coordinates
  // against the sizes in use; the back only needs the neighbour positions.
  logic          cmd_valid;
  logic          cmd_pop;
  bts_pkg::cmd_t cmd;

  // Front end: accepts a transaction whenever its 4-deep queue has room,
  // independent of whether the back end is stalled on a full result queue.
  bts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .in_item_i   (in_item_i),
    .full_o      (full_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back end: writes go straight to one bank; samples issue only with a free
  // result slot reserved, so the blend pipeline itself never stalls. Writes
  // and reads leave in order, so a sample always sees every earlier write.
  bts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .out_item_o  (out_item_o)
  );

endmodule

### src/bts_checker.sv
// ----------------------------------------------------------------------------
// bts_checker
// Port-level checks on the sampler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bts_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       push_i,
  input bts_pkg::in_item_t          in_item_i,
  input logic                       full_o,
  input logic                       empty_o,
  input logic                       pop_i,
  input bts_pkg::out_item_t         out_item_o
);

  // samples accepted and not yet taken
  logic [4:0] pending_q;
  logic       samp_in, res_out;

  assign samp_in = push_i && !full_o && (in_item_i.op == bts_pkg::OP_SAMPLE);
  assign res_out = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 5'(samp_in) - 5'(res_out);
    end
  end

  // a result only exists for a sample that went in
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (pending_q != '0))
    else $error("result shown with no sample outstanding");

  a_full_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_o) |-> $past(push_i))
    else $error("queue went full without a transaction pushed");

  a_empty_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty_o) |-> $past(pop_i))
    else $error("result vanished without being popped");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(out_item_o)))
    else $error("waiting result changed before it was taken");

endmodule

bind bilinear_texture_sampler bts_checker u_checker (.*);

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bilinear texture sampler. Texels are loaded and
// sampled through the queue-style ports. A scoreboard object keeps its own copy
// of the texture and the size registers and works out the filtered colour of
// every sample. Results are compared in order, one channel at a time.
// ----------------------------------------------------------------------------

class sample_scoreboard;

  bts_pkg::rgb_t                texels  [bts_pkg::MAX_WIDTH*bts_pkg::MAX_HEIGHT];
  bit                           written [bts_pkg::MAX_WIDTH*bts_pkg::MAX_HEIGHT];
  logic [bts_pkg::SIZE_W-1:0]   width_reg    = bts_pkg::SIZE_RESET;
  logic [bts_pkg::SIZE_W-1:0]   height_reg   = bts_pkg::SIZE_RESET;
  bts_pkg::out_item_t           pending_colours[$];
  int unsigned                  mismatches   = 0;
  int unsigned                  samples_seen = 0;
  int unsigned                  texel_writes = 0;

  function void set_register(bts_pkg::cfg_reg_e idx, logic [bts_pkg::SIZE_W-1:0] v);
    if (idx == bts_pkg::CFG_TEXTURE_WIDTH) width_reg = v;
    else height_reg = v;
  endfunction

  // zero reads as one, anything past the store saturates
  function int unsigned clamp_size(logic [bts_pkg::SIZE_W-1:0] r, int unsigned maxv);
    if (r == 0) return 1;
    if (r > maxv) return maxv;
    return r;
  endfunction

  function int unsigned used_width();
    return clamp_size(width_reg, bts_pkg::MAX_WIDTH);
  endfunction

  function int unsigned used_height();
    return clamp_size(height_reg, bts_pkg::MAX_HEIGHT);
  endfunction

  function int unsigned outstanding();
    return pending_colours.size();
  endfunction

  function bit is_written(int unsigned x, int unsigned y);
    return written[y*bts_pkg::MAX_WIDTH + x];
  endfunction

  // lower and upper neighbours, clamped to the edge of the texture in use
  function void corners(input logic [bts_pkg::SAMPLE_W-1:0] sx, sy,
                        output int unsigned x0, x1, y0, y1);
    int unsigned w, h;
    w  = used_width();
    h  = used_height();
    x0 = sx >> bts_pkg::FRAC_BITS;
    y0 = sy >> bts_pkg::FRAC_BITS;
    if (x0 > w - 1) x0 = w - 1;
    if (y0 > h - 1) y0 = h - 1;
    x1 = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;
    y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
  endfunction

  // a + floor(((b-a)*t + half) / 2^FRAC_BITS); >>> on a signed int floors
  function logic [7:0] blend_channel(logic [7:0] a, logic [7:0] b,
                                     logic [bts_pkg::FRAC_BITS-1:0] t);
    int d, p;
    d = int'(b) - int'(a);
    p = d * int'(t) + (1 << (bts_pkg::FRAC_BITS - 1));
    p = p >>> bts_pkg::FRAC_BITS;
    return 8'(int'(a) + p);
  endfunction

  function bts_pkg::rgb_t blend_colour(bts_pkg::rgb_t c0, bts_pkg::rgb_t c1,
                                       logic [bts_pkg::FRAC_BITS-1:0] t);
    bts_pkg::rgb_t m;
    m.red   = blend_channel(c0.red,   c1.red,   t);
    m.green = blend_channel(c0.green, c1.green, t);
    m.blue  = blend_channel(c0.blue,  c1.blue,  t);
    return m;
  endfunction

  // called for every accepted input transaction
  function void note_item(bts_pkg::in_item_t it);
    int unsigned        x0, x1, y0, y1, idx;
    bts_pkg::rgb_t      top, bottom, mix;
    bts_pkg::out_item_t res;
    if (it.op == bts_pkg::OP_WRITE) begin
      idx = int'(it.texel_y) * bts_pkg::MAX_WIDTH + int'(it.texel_x);
      texels[idx]  = {it.in_red, it.in_green, it.in_blue};
      written[idx] = 1'b1;
      texel_writes++;
    end else begin
      corners(it.sample_x, it.sample_y, x0, x1, y0, y1);
      top    = blend_colour(texels[y0*bts_pkg::MAX_WIDTH + x0],
                            texels[y0*bts_pkg::MAX_WIDTH + x1],
                            it.sample_x[bts_pkg::FRAC_BITS-1:0]);
      bottom = blend_colour(texels[y1*bts_pkg::MAX_WIDTH + x0],
                            texels[y1*bts_pkg::MAX_WIDTH + x1],
                            it.sample_x[bts_pkg::FRAC_BITS-1:0]);
      mix    = blend_colour(top, bottom, it.sample_y[bts_pkg::FRAC_BITS-1:0]);
      res.out_red   = mix.red;
      res.out_green = mix.green;
      res.out_blue  = mix.blue;
      pending_colours.push_back(res);
    end
  endfunction

  function void compare_channel(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // called for every accepted result transaction
  function void check_colour(bts_pkg::out_item_t got);
    bts_pkg::out_item_t want;
    if (pending_colours.size() == 0) begin
      $display("%0t: result %h with no sample outstanding, expected none",
               $time, got);
      mismatches++;
      return;
    end
    want = pending_colours.pop_front();
    samples_seen++;
    compare_channel("red",   want.out_red,   got.out_red);
    compare_channel("green", want.out_green, got.out_green);
    compare_channel("blue",  want.out_blue,  got.out_blue);
  endfunction

endclass

module testbench;

  localparam int ITEM_TARGET  = 1950;
  localparam int MAX_GAP      = 14;
  localparam int HOLD_CYCLES  = 90;  // receiver stall, long enough to back up the input
  localparam int BURST        = 60;
  localparam int DRAIN_CYCLES = 8;   // waits out write transactions in flight; writes leave no result to wait on
  localparam int TAIL_CYCLES  = 20;
  localparam int IN_W         = $bits(bts_pkg::in_item_t);

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        push;
  logic                        full;
  logic                        empty;
  logic                        pop;
  bts_pkg::in_item_t           in_item;
  bts_pkg::out_item_t          out_item;
  logic                        cfg_valid;
  logic                        cfg_ready;
  bts_pkg::cfg_reg_e           cfg_index;
  logic [bts_pkg::SIZE_W-1:0]  cfg_data;

  sample_scoreboard    board = new();

  bit                  send_idle;
  bit                  recv_idle;
  bit                  hold_request;
  int unsigned         items_sent  = 0;
  int unsigned         full_stalls = 0;
  int unsigned         holds_done  = 0;
  int unsigned         pauses      = 0;
  int unsigned         cfg_writes  = 0;

  bilinear_texture_sampler i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push_i      (push),
    .in_item_i   (in_item),
    .full_o      (full),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #6 clk = ~clk;

  // Hard stop. The slowest legal run (every item and result waiting out the
  // longest gap, fill writes, stalls and drain pauses) stays well under a
  // tenth of this.
  initial begin
    #(10_000_000);
    $display("Run timed out at %0t", $time);
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender side. Every task starts and ends at a falling edge; push stays high
  // across back-to-back transactions and is lowered only for gaps, size changes, pauses and the end.
  // --------------------------------------------------------------------------
  task automatic send(input bts_pkg::in_item_t it);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) begin
      full_stalls++;
      @(posedge clk);
    end
    board.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  // sample fields of a write are don't-care, so they carry noise
  task automatic write_texel(input int unsigned x, y, input bts_pkg::rgb_t c);
    bts_pkg::in_item_t it;
    it          = IN_W'({$urandom(), $urandom(), $urandom()});
    it.op       = bts_pkg::OP_WRITE;
    it.texel_x  = bts_pkg::COORD_W'(x);
    it.texel_y  = bts_pkg::COORD_W'(y);
    it.in_red   = c.red;
    it.in_green = c.green;
    it.in_blue  = c.blue;
    send(it);
  endtask

  // Loads any of the four neighbours not yet written, then samples. This keeps
  // the bench away from reading texels the store has never held.
  task automatic sample_at(input logic [bts_pkg::SAMPLE_W-1:0] sx, sy);
    bts_pkg::in_item_t it;
    int unsigned       x0, x1, y0, y1, cx, cy;
    board.corners(sx, sy, x0, x1, y0, y1);
    for (int k = 0; k < 4; k++) begin
      cx = k[0] ? x1 : x0;
      cy = k[1] ? y1 : y0;
      if (!board.is_written(cx, cy))
        write_texel(cx, cy, bts_pkg::rgb_t'(24'($urandom())));
    end
    it          = IN_W'({$urandom(), $urandom(), $urandom()});
    it.op       = bts_pkg::OP_SAMPLE;
    it.sample_x = sx;
    it.sample_y = sy;
    send(it);
  endtask

  // Size registers change only with the block idle: results drained, then a
  // wait for any write transactions still in flight.
  task automatic set_size(input bts_pkg::cfg_reg_e idx,
                          input logic [bts_pkg::SIZE_W-1:0] v);
    push <= 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(idx, v);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one axis of a sample position: mostly inside, with edge fractions and
  // integer parts past the last texel mixed in
  function automatic logic [bts_pkg::SAMPLE_W-1:0] pick_coord(input int unsigned used);
    logic [7:0] whole, frac;
    whole = 8'($urandom_range(0, used - 1));
    frac  = 8'($urandom());
    case ($urandom_range(0, 9))
      0: frac  = 8'h00;
      1: frac  = 8'hFF;
      2: frac  = 8'h80;
      3: whole = 8'(used - 1);
      4: whole = 8'($urandom_range(used - 1, 255));
      5: return bts_pkg::SAMPLE_W'($urandom());
      default: ;
    endcase
    return {whole, frac};
  endfunction

  // mostly small textures so they fill and get resampled; extremes often
  function automatic logic [bts_pkg::SIZE_W-1:0] draw_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return bts_pkg::SIZE_W'(1);
      2: return bts_pkg::SIZE_RESET;
      3: return bts_pkg::SIZE_W'($urandom_range(257, 511));
      4: return bts_pkg::SIZE_W'($urandom_range(1, 511));
      default: return bts_pkg::SIZE_W'($urandom_range(2, 12));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side, in a process of its own. On request it holds pop low for a
  // fixed stretch so the result queue backs up into the input.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        holds_done++;
      end
      gap = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      board.check_colour(out_item);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase, phase_len, r;
    logic [bts_pkg::SIZE_W-1:0] w_val, h_val;

    rst_n        = 1'b0;
    push         = 1'b0;
    in_item      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = bts_pkg::CFG_TEXTURE_WIDTH;
    cfg_data     = '0;
    send_idle    = 1'b1;
    recv_idle    = 1'b1;
    hold_request = 1'b0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part, texture at its reset size of 256 x 256 ----
    write_texel(0, 0, bts_pkg::rgb_t'(24'h000000));
    write_texel(1, 0, bts_pkg::rgb_t'(24'hFFFFFF));
    write_texel(0, 1, bts_pkg::rgb_t'(24'hFF0080));
    write_texel(1, 1, bts_pkg::rgb_t'(24'h01FE7F));
    sample_at(16'h0000, 16'h0000);   // exactly on a texel
    sample_at(16'h0080, 16'h0000);   // half-way 0 -> 255, tie rounds up
    sample_at(16'h0100, 16'h0080);   // half-way with falling channels, ties below zero
    sample_at(16'h00FF, 16'h00FF);   // largest fraction on both axes
    write_texel(255, 255, bts_pkg::rgb_t'(24'h123456));
    sample_at(16'hFFFF, 16'hFFFF);   // last texel, both neighbours clamped to it
    sample_at(16'hFF80, 16'hFE40);   // clamped in x, blended between the last rows

    // zero width reads as one column, an oversize height saturates
    set_size(bts_pkg::CFG_TEXTURE_WIDTH,  '0);
    set_size(bts_pkg::CFG_TEXTURE_HEIGHT, bts_pkg::SIZE_W'(511));
    write_texel(200, 3, bts_pkg::rgb_t'(24'hA5C3E7));  // outside the columns in use, kept
    sample_at(16'hFFFF, 16'h1234);
    set_size(bts_pkg::CFG_TEXTURE_WIDTH,  bts_pkg::SIZE_W'(511));
    sample_at(16'hC840, 16'h0300);   // blends in the texel written out of range
    set_size(bts_pkg::CFG_TEXTURE_HEIGHT, '0);
    sample_at(16'h3080, 16'hFFFF);   // single row

    // ---- random part, in phases of one size setting each ----
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      w_val = (phase % 5 == 2) ? bts_pkg::SIZE_W'($urandom_range(2, 6)) : draw_size();
      h_val = (phase % 5 == 2) ? bts_pkg::SIZE_W'($urandom_range(2, 6)) : draw_size();
      set_size(bts_pkg::CFG_TEXTURE_WIDTH,  w_val);
      set_size(bts_pkg::CFG_TEXTURE_HEIGHT, h_val);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);

      if (phase % 5 == 2) begin
        // receiver stops while samples keep coming back to back
        send_idle    = 1'b0;
        hold_request = 1'b1;
        repeat (BURST) sample_at(pick_coord(board.used_width()),
                                 pick_coord(board.used_height()));
      end

      phase_len = $urandom_range(40, 120);
      for (int n = 0; n < phase_len; n++) begin
        if (phase % 5 == 4 && n == phase_len / 2) begin
          // sender waits for every outstanding result before going on
          push <= 1'b0;
          do @(negedge clk); while (board.outstanding() != 0);
          pauses++;
        end
        r = $urandom_range(0, 99);
        if (r < 70)
          sample_at(pick_coord(board.used_width()), pick_coord(board.used_height()));
        else if (r < 88)
          write_texel($urandom_range(0, board.used_width() - 1),
                      $urandom_range(0, board.used_height() - 1),
                      bts_pkg::rgb_t'(24'($urandom())));
        else
          write_texel($urandom_range(0, 255), $urandom_range(0, 255),
                      bts_pkg::rgb_t'(24'($urandom())));
      end
      phase++;
    end

    // ---- wind down ----
    push <= 1'b0;
    do @(negedge clk); while (board.outstanding() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d transactions: %0d texel writes, %0d samples checked, %0d size writes",
             items_sent, board.texel_writes, board.samples_seen, cfg_writes);
    $display("%0d receiver stalls, %0d sender drain pauses, %0d cycles with input held off",
             holds_done, pauses, full_stalls);
    if (board.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
